/* hw/rtl/ptw_pkg.sv */
package ptw_pkg;

  // Field widths
  localparam int unsigned VaBits    = 48;
  localparam int unsigned EntryBits = 64;
  localparam int unsigned AddrBits  = 52;
  localparam int unsigned IdxBits   = 9;
  localparam int unsigned OffBits   = 12;

  // Result kinds
  localparam logic [1:0] KindReq   = 2'd0;
  localparam logic [1:0] KindDone  = 2'd1;
  localparam logic [1:0] KindFault = 2'd2;
  localparam logic [1:0] KindIdle  = 2'd3;

  // Input opcodes
  localparam logic OpStart = 1'b0;
  localparam logic OpEntry = 1'b1;

  // Walk level codes; Idle means no walk pending
  localparam logic [2:0] LvlTop  = 3'd0;
  localparam logic [2:0] LvlDir1 = 3'd1;
  localparam logic [2:0] LvlDir2 = 3'd2;
  localparam logic [2:0] LvlLeaf = 3'd3;
  localparam logic [2:0] LvlIdle = 3'd4;

  // Entry bit positions
  localparam int unsigned PresentBit  = 0;
  localparam int unsigned PageSizeBit = 7;

  // Pick the 9-bit table index of a virtual address for one level
  function automatic logic [IdxBits-1:0] level_index(input logic [VaBits-1:0] va,
                                                      input logic [1:0]        lvl);
    logic [IdxBits-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

/* hw/rtl/four_level_page_table_walker.sv */
// Channel   Dir  Words                 Payload
// s_axis    in   start / table entry   tuser: opcode; tdata: virt_addr, entry_data
// m_axis    out  request/done/fault    tuser: result_kind; tdata: out_address, fault_level
// cfg       in   root register write   cfg_wdata_i: page_table_root
//
// One word is accepted per cycle while s_axis_tready is high; each result passes through the input
// register, then the result register, and is set by the single walk-state update.
// A stalled result register holds the input register, which then drops s_axis_tready.
// Reset clears the walk to idle and the root register to zero.
module four_level_page_table_walker
  import ptw_pkg::*;
#(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [AddrBits-1:0]         cfg_wdata_i,    // page_table_root
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [VaBits+EntryBits-1:0] s_axis_tdata,   // [47:0] virt_addr, [111:48] entry_data
  input  logic                        s_axis_tuser,   // [0] opcode
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,   // [51:0] out_address, [53:52] fault_level
  output logic [1:0]                  m_axis_tuser    // [1:0] result_kind
);

  localparam logic [63:0]         PhysMask64 = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
  localparam logic [AddrBits-1:0] PhysMask   = PhysMask64[AddrBits-1:0];
  localparam logic [AddrBits-1:0] BaseMask   = PhysMask & ~AddrBits'(12'hFFF);

  logic [AddrBits-1:0]  root_q;
  logic [2:0]           walk_level_q, walk_level_d;
  logic [VaBits-1:0]    held_va_q, held_va_d;

  logic                 in_valid_q;
  logic                 in_op_q;
  logic [VaBits-1:0]    in_va_q;
  logic [EntryBits-1:0] in_entry_q;

  logic                 out_valid_q;
  logic [1:0]           out_kind_q, out_kind_d;
  logic [AddrBits-1:0]  out_addr_q, out_addr_d;
  logic [1:0]           out_lvl_q, out_lvl_d;

  logic                 out_free;
  logic                 adv;
  logic [AddrBits-1:0]  entry_base;
  logic                 present;
  logic                 page_size;
  logic [1:0]           cur_lvl;

  // Handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Root register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q    <= s_axis_tuser;
      in_va_q    <= s_axis_tdata[VaBits-1:0];
      in_entry_q <= s_axis_tdata[VaBits+EntryBits-1:VaBits];
    end
  end

  // Check the entry and form the next address
  assign entry_base = in_entry_q[AddrBits-1:0] & BaseMask;
  assign present    = in_entry_q[PresentBit];
  assign page_size  = in_entry_q[PageSizeBit];
  assign cur_lvl    = walk_level_q[1:0];

  always_comb begin
    walk_level_d = walk_level_q;
    held_va_d    = held_va_q;
    out_kind_d   = KindIdle;
    out_addr_d   = '0;
    out_lvl_d    = '0;
    if (in_op_q == OpStart) begin
      held_va_d    = in_va_q;
      walk_level_d = LvlTop;
      out_kind_d   = KindReq;
      out_addr_d   = (root_q & BaseMask)
                   | {{(AddrBits-OffBits){1'b0}}, level_index(in_va_q, 2'd0), 3'b000};
    end else if (walk_level_q == LvlIdle) begin
      out_kind_d = KindIdle;
    end else if (!present || (page_size && (walk_level_q == LvlDir1 ||
                                            walk_level_q == LvlDir2))) begin
      walk_level_d = LvlIdle;
      out_kind_d   = KindFault;
      out_lvl_d    = cur_lvl;
    end else if (walk_level_q == LvlLeaf) begin
      walk_level_d = LvlIdle;
      out_kind_d   = KindDone;
      out_addr_d   = (entry_base | {{(AddrBits-OffBits){1'b0}}, held_va_q[OffBits-1:0]})
                   & PhysMask;
    end else begin
      walk_level_d = walk_level_q + 3'd1;
      out_kind_d   = KindReq;
      out_addr_d   = entry_base
                   | {{(AddrBits-OffBits){1'b0}},
                      level_index(held_va_q, cur_lvl + 2'd1), 3'b000};
    end
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_level_q <= LvlIdle;
    end else if (adv) begin
      walk_level_q <= walk_level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      held_va_q <= held_va_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kind_q <= out_kind_d;
      out_addr_q <= out_addr_d;
      out_lvl_q  <= out_lvl_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {2'b00, out_lvl_q, out_addr_q};

  // Checks
  a_fault_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && out_kind_d == KindFault) |=> (walk_level_q == LvlIdle))
    else $error("walk not idle after fault");

  a_start_goes_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_op_q == OpStart) |=> (walk_level_q == LvlTop && out_kind_q == KindReq))
    else $error("start did not begin walk at top level");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_entry_q)))
    else $error("input word lost under stall");

endmodule

/* tb/ptw_result_checker.sv */
`timescale 1ns / 1ps

module ptw_result_checker
  import ptw_pkg::*;
#(
  parameter int unsigned PHYS_ADDR_BITS = 52
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [AddrBits-1:0]         cfg_wdata_i,    // page_table_root
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [VaBits+EntryBits-1:0] s_axis_tdata,   // [47:0] virt_addr, [111:48] entry_data
  input  logic                        s_axis_tuser,   // [0] opcode
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [55:0]                 m_axis_tdata,   // [51:0] out_address, [53:52] fault_level
  input  logic [1:0]                  m_axis_tuser,   // [1:0] result_kind
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam logic [63:0] PhysMask = (64'd1 << PHYS_ADDR_BITS) - 64'd1;

  typedef struct packed {
    logic [1:0]          kind;
    logic [AddrBits-1:0] addr;
    logic [1:0]          lvl;
  } walk_rsp_t;

  // Shadow of the walker's state and root register
  logic [AddrBits-1:0] root_reg;
  logic [2:0]          cur_level;
  logic [VaBits-1:0]   held_va;

  walk_rsp_t           awaited_responses[$];
  walk_rsp_t           want;
  int                  fails;

  // Page-aligned base of a table pointer, cut to the physical width
  function automatic logic [AddrBits-1:0] table_base(input logic [63:0] ptr);
    logic [63:0] t;
    t = ptr & PhysMask & ~64'hFFF;
    return t[AddrBits-1:0];
  endfunction

  // Byte offset of the entry for one level within its table
  function automatic logic [AddrBits-1:0] entry_offset(input logic [2:0] lvl);
    int                sh;
    logic [VaBits-1:0] sh_va;
    sh    = 39 - 9 * int'(lvl[1:0]);
    sh_va = held_va >> sh;
    return {40'd0, sh_va[8:0], 3'b000};
  endfunction

  // Advance the shadow walk by one word and give the response it causes
  function automatic walk_rsp_t walk_response(input logic              op,
                                              input logic [VaBits-1:0] va,
                                              input logic [63:0]       ent);
    walk_rsp_t  r;
    logic [2:0] lvl;
    r = '0;
    if (op == OpStart) begin
      held_va   = va;
      cur_level = LvlTop;
      r.kind    = KindReq;
      r.addr    = table_base({12'd0, root_reg}) | entry_offset(LvlTop);
    end else if (cur_level == LvlIdle) begin
      r.kind = KindIdle;
    end else begin
      lvl = cur_level;
      if (!ent[PresentBit] || ((lvl == LvlDir1 || lvl == LvlDir2) && ent[PageSizeBit])) begin
        cur_level = LvlIdle;
        r.kind    = KindFault;
        r.lvl     = lvl[1:0];
      end else if (lvl == LvlLeaf) begin
        cur_level = LvlIdle;
        r.kind    = KindDone;
        r.addr    = table_base(ent) | {40'd0, held_va[11:0]};
      end else begin
        cur_level = lvl + 3'd1;
        r.kind    = KindReq;
        r.addr    = table_base(ent) | entry_offset(cur_level);
      end
    end
    return r;
  endfunction

  // Compare each result word with the oldest prediction, then predict for new input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_reg  = '0;
      cur_level = LvlIdle;
      held_va   = '0;
      fails     = 0;
      awaited_responses.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) root_reg = cfg_wdata_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_responses.size() == 0) begin
          $error("unexpected result word: kind %0d, address %h", m_axis_tuser,
                 m_axis_tdata[51:0]);
          fails++;
        end else begin
          want = awaited_responses.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("result_kind mismatch: expected %0d, got %0d", want.kind, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[51:0] !== want.addr) begin
            $error("out_address mismatch: expected %h, got %h", want.addr,
                   m_axis_tdata[51:0]);
            fails++;
          end
          if (m_axis_tdata[53:52] !== want.lvl) begin
            $error("fault_level mismatch: expected %0d, got %0d", want.lvl,
                   m_axis_tdata[53:52]);
            fails++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        awaited_responses.push_back(walk_response(s_axis_tuser, s_axis_tdata[47:0],
                                                  s_axis_tdata[111:48]));

      fail_count_o <= fails;
      pending_o    <= awaited_responses.size();
    end
  end

endmodule

/* tb/tb_four_level_page_table_walker.sv */
`timescale 1ns / 1ps

module tb_four_level_page_table_walker
  import ptw_pkg::*;
();

  typedef enum logic [1:0] {RxOpen, RxMostly, RxSparse, RxBlocks} rx_mode_e;

  localparam logic [AddrBits-1:0] RootOnes = {AddrBits{1'b1}};
  localparam logic [63:0]         AllOnes  = {64{1'b1}};

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we        = 1'b0;
  logic [AddrBits-1:0]         cfg_wdata     = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [VaBits+EntryBits-1:0] s_axis_tdata  = '0;  // [47:0] virt_addr, [111:48] entry_data
  logic                        s_axis_tuser  = 1'b0; // [0] opcode
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [55:0]                 m_axis_tdata;         // [51:0] out_address, [53:52] fault_level
  logic [1:0]                  m_axis_tuser;         // [1:0] result_kind

  int       fail_count;
  int       pending;
  int       items_sent = 0;
  int       burst_left = 0;
  logic     calm       = 1'b0;
  rx_mode_e rx_mode    = RxOpen;
  int       rx_count   = 0;

  four_level_page_table_walker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ptw_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #10 clk_i = ~clk_i;

  // Stall the result side: pick a new random pattern whenever the current one runs out
  always @(posedge clk_i) begin
    if (rx_count == 0) begin
      rx_mode  <= rx_mode_e'($urandom_range(0, 3));
      rx_count <= $urandom_range(16, 96);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      RxOpen:   m_axis_tready <= 1'b1;
      RxMostly: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RxSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready <= rx_count[2];
    endcase
  end

  function automatic logic [VaBits-1:0] rand_va();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VaBits-1:0];
  endfunction

  function automatic logic [63:0] rand_entry();
    return {$urandom, $urandom};
  endfunction

  // Offer one word, with a random gap at the start of each burst unless calm; leave tvalid high
  task automatic send_word(input logic op, input logic [VaBits-1:0] va,
                           input logic [63:0] ent);
    int gap;
    if (burst_left == 0) begin
      gap        = calm ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {ent, va};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Hold off the sender until every predicted result has been seen
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [AddrBits-1:0] root);
    cfg_wdata <= root;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // One walk with random content: mostly present entries, sometimes abandoned
  task automatic run_walk();
    logic [63:0] ent;
    send_word(OpStart, rand_va(), rand_entry());
    for (int l = 0; l < 4; l++) begin
      if ($urandom_range(0, 39) == 0) return;
      ent = rand_entry();
      ent[PresentBit] = ($urandom_range(0, 11) != 0);
      if (l == 1 || l == 2) ent[PageSizeBit] = ($urandom_range(0, 7) == 0);
      send_word(OpEntry, rand_va(), ent);
      if (!ent[PresentBit] || ((l == 1 || l == 2) && ent[PageSizeBit])) return;
    end
  endtask

  task automatic random_phase(input int n_items);
    int first;
    int pick;
    first = items_sent;
    calm  = ($urandom_range(0, 3) == 0);
    while (items_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)
        send_word(OpEntry, rand_va(), rand_entry());
      else if (pick < 8)
        wait_drained();
      else
        run_walk();
    end
  endtask

  initial begin : stimulus
    logic [AddrBits-1:0] root;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Entry with nothing pending, then a full walk with all address bits set
    write_root(RootOnes);
    send_word(OpEntry, rand_va(), AllOnes);
    send_word(OpStart, {VaBits{1'b1}}, rand_entry());
    send_word(OpEntry, rand_va(), AllOnes);
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'hFFFF_FFFF_FFFF_FF7F);
    send_word(OpEntry, rand_va(), AllOnes);
    // Not present at the top level
    send_word(OpStart, '0, '0);
    send_word(OpEntry, '0, '0);
    // Large page at the second and third levels
    send_word(OpStart, rand_va(), rand_entry());
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h81);
    send_word(OpStart, rand_va(), rand_entry());
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h81);
    // Not present at the leaf
    send_word(OpStart, rand_va(), rand_entry());
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h0);
    // Restart part way through a walk
    send_word(OpStart, rand_va(), rand_entry());
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpStart, rand_va(), rand_entry());
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h1);
    send_word(OpEntry, rand_va(), 64'h0);
    wait_drained();

    // Random phases, each under its own root setting
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       root = '0;
        1:       root = RootOnes;
        default: root = AddrBits'({$urandom, $urandom});
      endcase
      write_root(root);
      random_phase(320);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
